// ----- rtl/bakery_ticket_lock_arbiter_unit_macros.svh -----
// assertion macros shared by the ticket lock arbiter rtl
`ifndef BAKERY_TICKET_LOCK_ARBITER_UNIT_MACROS_SVH
`define BAKERY_TICKET_LOCK_ARBITER_UNIT_MACROS_SVH

// property checked on every clk edge outside reset
`define BTLA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition in one cycle implies a condition in the next cycle
`define BTLA_ASSERT_NEXT(lbl, cond, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

// ----- rtl/btla_pkg.sv -----
// types and constants for the bakery ticket lock arbiter
`default_nettype none
package btla_pkg;

	localparam int NUM_AGENTS_DEF   = 8;
	localparam int TICKET_WIDTH_DEF = 16;

	localparam int ACTIVE_W   = 4;
	localparam int AGENT_W    = 3;
	localparam int TICKET_OUT_W = 16;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

	// register index taken from paddr[2]
	localparam logic REG_ACTIVE_AGENTS = 1'b0;

	typedef enum logic {
		REQ_ACQUIRE = 1'b0,
		REQ_RELEASE = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DUP      = 2'd1,
		ST_RANGE    = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_MAX,
		S_UPDATE,
		S_SCAN_MIN,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

// ----- rtl/bakery_ticket_lock_arbiter_unit.sv -----
// bakery ticket lock arbiter: ticket table, scan sequencer and apb register
//
// channel   direction  handshake                       payload
// config    in/out     psel, penable, pwrite, pready   paddr, pwdata, prdata
// request   in         start high while busy low       req_type, agent_id
// result    out        done strobe, one cycle          holder_valid, holder_agent,
//                                                      ticket, status
//
// an item keeps the block busy until its done strobe; one shared comparator walks the
// ticket memory twice over the active agent count, once for the largest ticket and once
// for the holder, one entry per cycle through the registered read port
// reset clears the ticket table at once through per-entry valid bits
// results cannot be stalled; done is high for exactly one cycle per item
`include "bakery_ticket_lock_arbiter_unit_macros.svh"
`default_nettype none
module bakery_ticket_lock_arbiter_unit
	import btla_pkg::*;
#(
	parameter int NUM_AGENTS   = NUM_AGENTS_DEF,
	parameter int TICKET_WIDTH = TICKET_WIDTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [APB_ADDR_W-1:0]   paddr,
	input  wire logic [APB_DATA_W-1:0]   pwdata,
	output logic      [APB_DATA_W-1:0]   prdata,
	output logic                         pready,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic                    req_type,
	input  wire logic [AGENT_W-1:0]      agent_id,
	output logic                         done,
	output logic                         holder_valid,
	output logic      [AGENT_W-1:0]      holder_agent,
	output logic      [TICKET_OUT_W-1:0] ticket,
	output logic      [1:0]              status
);

	localparam int AW = $clog2(NUM_AGENTS);
	localparam int CW = $clog2(NUM_AGENTS + 1);
	localparam int TW = TICKET_WIDTH;

	state_t state_q, state_d;

	logic [ACTIVE_W-1:0] active_q;
	logic [CW-1:0]       count;
	logic                cfg_wr;

	req_t                req_q;
	logic [AGENT_W-1:0]  agent_q;
	logic [CW-1:0]       idx_q;

	logic [TW-1:0]       mem [NUM_AGENTS];
	logic [NUM_AGENTS-1:0] valid_q;
	logic [TW-1:0]       rd_data_s1;
	logic                rd_ok_s1;
	logic                rd_live_s1;
	logic [CW-1:0]       rd_idx_s1;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       wr_addr;
	logic [TW-1:0]       entry_v;

	logic [TW-1:0]       maxv_q;
	logic [TW-1:0]       own_q;
	logic                found_q;
	logic [TW-1:0]       bestv_q;
	logic [CW-1:0]       best_q;
	logic [TW-1:0]       tick_q;
	status_t             status_q;

	// shared comparator
	logic [TW-1:0]       cmp_a, cmp_b;
	logic                cmp_lt;

	logic                accept;
	logic                scanning;
	logic                issue;
	logic                upd;
	logic                in_range;
	logic                wr_ticket;
	logic                clr_ticket;
	logic [TW-1:0]       next_tick;
	status_t             next_status;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_ACTIVE_AGENTS) ?
		APB_DATA_W'(active_q) : '0;

	always_comb begin
		if (32'(active_q) > NUM_AGENTS) begin
			count = CW'(NUM_AGENTS);
		end else begin
			count = CW'(active_q);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_SCAN_MAX;
				end
			end
			S_SCAN_MAX: begin
				if (!issue) begin
					state_d = S_UPDATE;
				end
			end
			S_UPDATE: state_d = S_SCAN_MIN;
			S_SCAN_MIN: begin
				if (!issue) begin
					state_d = S_DONE;
				end
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy     = 1'b1;
		done     = 1'b0;
		scanning = 1'b0;
		upd      = 1'b0;
		case (state_q)
			S_IDLE:     busy = 1'b0;
			S_SCAN_MAX: scanning = 1'b1;
			S_UPDATE:   upd = 1'b1;
			S_SCAN_MIN: scanning = 1'b1;
			S_DONE:     done = 1'b1;
			default:    busy = 1'b1;
		endcase
	end

	assign accept  = start && !busy;
	assign issue   = scanning && (idx_q < count);
	assign rd_addr = idx_q[AW-1:0];
	assign wr_addr = AW'(agent_q);
	assign entry_v = rd_ok_s1 ? rd_data_s1 : '0;

	always_comb begin
		if (state_q == S_SCAN_MIN) begin
			cmp_a = entry_v;
			cmp_b = bestv_q;
		end else begin
			cmp_a = maxv_q;
			cmp_b = entry_v;
		end
	end
	assign cmp_lt = cmp_a < cmp_b;

	// decision taken between the two scans
	assign in_range = 32'(agent_q) < 32'(count);
	always_comb begin
		wr_ticket   = 1'b0;
		clr_ticket  = 1'b0;
		next_tick   = '0;
		next_status = ST_OK;
		if (!in_range) begin
			next_status = ST_RANGE;
		end else if (req_q == REQ_RELEASE) begin
			clr_ticket = 1'b1;
		end else if (own_q != '0) begin
			next_status = ST_DUP;
			next_tick   = own_q;
		end else if (maxv_q == '1) begin
			next_status = ST_OVERFLOW;
		end else begin
			wr_ticket = 1'b1;
			next_tick = maxv_q + TW'(1);
		end
	end

	// ticket memory, registered read
	always_ff @(posedge clk) begin
		if (upd && wr_ticket) begin
			mem[wr_addr] <= next_tick;
		end
		rd_data_s1 <= mem[rd_addr];
		rd_idx_s1  <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			active_q   <= ACTIVE_RESET;
			valid_q    <= '0;
			rd_ok_s1   <= 1'b0;
			rd_live_s1 <= 1'b0;
			idx_q      <= '0;
			found_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_ok_s1   <= valid_q[rd_addr];
			rd_live_s1 <= issue;
			if (cfg_wr && paddr[2] == REG_ACTIVE_AGENTS) begin
				active_q <= pwdata[ACTIVE_W-1:0];
			end
			if (upd && wr_ticket) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (upd && clr_ticket) begin
				valid_q[wr_addr] <= 1'b0;
			end
			if (accept || upd) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + CW'(1);
			end
			if (upd) begin
				found_q <= 1'b0;
			end else if (state_q == S_SCAN_MIN && rd_live_s1 && entry_v != '0 &&
					(!found_q || cmp_lt)) begin
				found_q <= 1'b1;
			end
		end
	end

	// scan datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req_t'(req_type);
			agent_q <= agent_id;
			maxv_q  <= '0;
			own_q   <= '0;
		end
		if (state_q == S_SCAN_MAX && rd_live_s1) begin
			if (cmp_lt) begin
				maxv_q <= entry_v;
			end
			if (32'(rd_idx_s1) == 32'(agent_q)) begin
				own_q <= entry_v;
			end
		end
		if (upd) begin
			tick_q   <= next_tick;
			status_q <= next_status;
			best_q   <= '0;
			bestv_q  <= '0;
		end else if (state_q == S_SCAN_MIN && rd_live_s1 && entry_v != '0 &&
				(!found_q || cmp_lt)) begin
			best_q  <= rd_idx_s1;
			bestv_q <= entry_v;
		end
	end

	assign holder_valid = found_q;
	assign holder_agent = AGENT_W'(best_q);
	assign ticket       = TICKET_OUT_W'(tick_q);
	assign status       = status_q;

	`BTLA_ASSERT_NEXT(a_accept_busy, accept, busy && state_q == S_SCAN_MAX && idx_q == '0,
		"accepted item did not start the max scan")
	`BTLA_ASSERT(a_done_after_scan, done |-> $past(state_q == S_SCAN_MIN),
		"result strobe not preceded by the holder scan")
	`BTLA_ASSERT(a_dup_has_ticket, (done && status_q == ST_DUP) |-> tick_q != '0,
		"duplicate acquire reported without a held ticket")
	`BTLA_ASSERT(a_no_holder_zero, (done && !found_q) |-> best_q == '0,
		"holder index not zero while no holder")

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// self-checking testbench for the bakery ticket lock arbiter
module tb_top
	import btla_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 2 * NUM_AGENTS_DEF + 20;
	localparam int MAX_PRINTS     = 20;
	localparam int CLIMB_ROUNDS   = 4;
	localparam logic [APB_ADDR_W-1:0] ADDR_ACTIVE = {REG_ACTIVE_AGENTS, 2'b00};
	localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED = {~REG_ACTIVE_AGENTS, 2'b00};
	localparam logic [TICKET_WIDTH_DEF-1:0] TICKET_TOP = '1;

	typedef struct {
		req_t               req;
		logic [AGENT_W-1:0] agent;
	} lock_req_t;

	typedef struct {
		logic                    holder_valid;
		logic [AGENT_W-1:0]      holder_agent;
		logic [TICKET_OUT_W-1:0] ticket;
		status_t                 status;
	} lock_grant_t;

	logic clk;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic req_type = 1'b0;
	logic [AGENT_W-1:0] agent_id = '0;
	logic done;
	logic holder_valid;
	logic [AGENT_W-1:0] holder_agent;
	logic [TICKET_OUT_W-1:0] ticket;
	logic [1:0] status;

	// local copy of the ticket table and the agent count register
	logic [TICKET_WIDTH_DEF-1:0] ticket_copy [NUM_AGENTS_DEF];
	logic [ACTIVE_W-1:0] active_copy;

	lock_req_t   request_q [$];
	lock_grant_t pending_grants [$];

	int errors = 0;
	int items_sent = 0;
	int grants_checked = 0;
	int reg_writes = 0;
	int status_seen [4];
	int stall_cycles = 0;
	int burst_left = 0;
	int idle_left = 0;
	bit gaps_on = 1'b1;

	bakery_ticket_lock_arbiter_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.agent_id(agent_id),
		.done(done),
		.holder_valid(holder_valid),
		.holder_agent(holder_agent),
		.ticket(ticket),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// applies one request to the local table and queues the grant it should produce
	task automatic arbitrate_request(req_t rq, logic [AGENT_W-1:0] ag);
		lock_grant_t g;
		int n;
		logic [TICKET_WIDTH_DEF-1:0] top;
		logic [TICKET_WIDTH_DEF-1:0] lowest;
		g.holder_valid = 1'b0;
		g.holder_agent = '0;
		g.ticket = '0;
		g.status = ST_OK;
		n = (active_copy > NUM_AGENTS_DEF) ? NUM_AGENTS_DEF : int'(active_copy);
		if (int'(ag) >= n) begin
			g.status = ST_RANGE;
		end else if (rq == REQ_ACQUIRE) begin
			if (ticket_copy[ag] != 0) begin
				g.status = ST_DUP;
				g.ticket = ticket_copy[ag];
			end else begin
				top = '0;
				for (int k = 0; k < n; k++)
					if (ticket_copy[k] > top)
						top = ticket_copy[k];
				if (top == TICKET_TOP) begin
					g.status = ST_OVERFLOW;
				end else begin
					ticket_copy[ag] = top + 1'b1;
					g.ticket = ticket_copy[ag];
				end
			end
		end else begin
			ticket_copy[ag] = '0;
		end
		lowest = '0;
		// strict less-than keeps the lower index on equal tickets
		for (int k = 0; k < n; k++) begin
			if (ticket_copy[k] != 0 && (!g.holder_valid || ticket_copy[k] < lowest)) begin
				g.holder_valid = 1'b1;
				g.holder_agent = AGENT_W'(k);
				lowest = ticket_copy[k];
			end
		end
		status_seen[g.status]++;
		pending_grants.push_back(g);
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// sender: bursts of items with random gaps, noise on the fields while start is low
	always @(posedge clk) begin
		lock_req_t nxt;
		if (arst_n) begin
			if (start && !busy) begin
				arbitrate_request(req_t'(req_type), agent_id);
				items_sent++;
			end
			if (!start || !busy) begin
				if (idle_left > 0) begin
					idle_left--;
					start <= 1'b0;
					req_type <= 1'($urandom);
					agent_id <= AGENT_W'($urandom);
				end else if (request_q.size() != 0) begin
					nxt = request_q.pop_front();
					start <= 1'b1;
					req_type <= nxt.req;
					agent_id <= nxt.agent;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						if (gaps_on && $urandom_range(0, 2) != 0)
							idle_left = $urandom_range(1, 15);
					end
				end else begin
					start <= 1'b0;
					req_type <= 1'($urandom);
					agent_id <= AGENT_W'($urandom);
				end
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		lock_grant_t g;
		if (arst_n && done) begin
			if (pending_grants.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				g = pending_grants.pop_front();
				grants_checked++;
				if (holder_valid !== g.holder_valid)
					report_mismatch("holder_valid", holder_valid, g.holder_valid);
				if (holder_agent !== g.holder_agent)
					report_mismatch("holder_agent", holder_agent, g.holder_agent);
				if (ticket !== g.ticket)
					report_mismatch("ticket", ticket, g.ticket);
				if (status !== g.status)
					report_mismatch("status", status, g.status);
			end
		end
	end

	// ends the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (psel && penable)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	task automatic queue_request(req_t rq, logic [AGENT_W-1:0] ag);
		lock_req_t r;
		r.req = rq;
		r.agent = ag;
		request_q.push_back(r);
	endtask

	// returns on a clock edge once every queued item has been granted
	task automatic wait_drained();
		do
			@(posedge clk);
		while (request_q.size() != 0 || start || pending_grants.size() != 0);
		@(posedge clk);
	endtask

	task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_ACTIVE)
			active_copy = data[ACTIVE_W-1:0];
		reg_writes++;
	endtask

	task automatic queue_random(int cnt);
		int n;
		n = (active_copy > NUM_AGENTS_DEF) ? NUM_AGENTS_DEF : int'(active_copy);
		for (int i = 0; i < cnt; i++) begin
			// mostly agents in range, acquires a bit more often than releases
			if (n > 0 && $urandom_range(0, 4) != 0)
				queue_request($urandom_range(0, 9) < 6 ? REQ_ACQUIRE : REQ_RELEASE,
					AGENT_W'($urandom_range(0, n - 1)));
			else
				queue_request(req_t'($urandom_range(0, 1)), AGENT_W'($urandom));
		end
	endtask

	initial begin
		logic [ACTIVE_W-1:0] cfg;
		for (int k = 0; k < NUM_AGENTS_DEF; k++)
			ticket_copy[k] = '0;
		active_copy = ACTIVE_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all agents after reset: duplicates, release without a ticket, holder hand-off
		queue_request(REQ_RELEASE, 0);
		queue_request(REQ_ACQUIRE, 0);
		queue_request(REQ_ACQUIRE, 7);
		queue_request(REQ_ACQUIRE, 0);
		queue_request(REQ_ACQUIRE, 3);
		queue_request(REQ_RELEASE, 0);
		queue_request(REQ_ACQUIRE, 0);
		queue_request(REQ_RELEASE, 7);
		queue_request(REQ_ACQUIRE, 6);
		wait_drained();

		// four agents: upper tickets kept but ignored, out of range agents
		apb_write(ADDR_ACTIVE, 32'd4);
		queue_request(REQ_ACQUIRE, 1);
		queue_request(REQ_ACQUIRE, 5);
		queue_request(REQ_RELEASE, 6);
		queue_request(REQ_RELEASE, 3);
		queue_request(REQ_RELEASE, 0);
		wait_drained();

		// count above the agent total saturates; agents 1 and 6 tie on one ticket
		apb_write(ADDR_ACTIVE, 32'd15);
		queue_request(REQ_ACQUIRE, 2);
		queue_request(REQ_RELEASE, 1);
		queue_request(REQ_ACQUIRE, 7);
		wait_drained();

		// no agent active
		apb_write(ADDR_ACTIVE, 32'd0);
		queue_request(REQ_ACQUIRE, 0);
		queue_request(REQ_RELEASE, 7);
		wait_drained();

		// a single agent, plus a write to an unmapped address that must change nothing
		apb_write(ADDR_ACTIVE, 32'd1);
		queue_request(REQ_ACQUIRE, 0);
		queue_request(REQ_ACQUIRE, 1);
		wait_drained();
		apb_write(ADDR_UNUSED, $urandom);
		queue_request(REQ_RELEASE, 0);
		queue_request(REQ_ACQUIRE, 0);
		wait_drained();

		// random traffic over several counts, upper data bits random
		for (int round = 0; round < 6; round++) begin
			case (round)
				0: cfg = 4'd8;
				1: cfg = 4'd2;
				2: cfg = 4'd1;
				3: cfg = ACTIVE_W'($urandom_range(9, 15));
				4: cfg = ACTIVE_W'($urandom_range(0, 15));
				default: cfg = ACTIVE_W'($urandom_range(3, 8));
			endcase
			apb_write(ADDR_ACTIVE, {(APB_DATA_W-ACTIVE_W)'($urandom), cfg});
			queue_random(35);
			// the test waits until every grant is back before queueing more
			wait_drained();
			queue_random(40);
			wait_drained();
		end

		// two agents leapfrog back to back, tickets keep climbing
		gaps_on = 1'b0;
		apb_write(ADDR_ACTIVE, 32'd2);
		queue_request(REQ_RELEASE, 0);
		queue_request(REQ_RELEASE, 1);
		queue_request(REQ_ACQUIRE, 0);
		queue_request(REQ_ACQUIRE, 1);
		for (int i = 0; i < CLIMB_ROUNDS; i++) begin
			queue_request(REQ_RELEASE, 0);
			queue_request(REQ_ACQUIRE, 0);
			queue_request(REQ_RELEASE, 1);
			queue_request(REQ_ACQUIRE, 1);
		end
		queue_request(REQ_RELEASE, 0);
		queue_request(REQ_ACQUIRE, 0);
		queue_request(REQ_ACQUIRE, 1);
		queue_request(REQ_RELEASE, 1);
		queue_request(REQ_ACQUIRE, 0);
		queue_request(REQ_ACQUIRE, 1);
		wait_drained();
		gaps_on = 1'b1;
		apb_write(ADDR_ACTIVE, 32'd8);
		queue_random(30);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("sent %0d requests over %0d register writes: %0d ok, %0d duplicate,",
			items_sent, reg_writes, status_seen[ST_OK], status_seen[ST_DUP]);
		$display("%0d out of range, %0d overflow; %0d results checked, %0d mismatches",
			status_seen[ST_RANGE], status_seen[ST_OVERFLOW], grants_checked, errors);
		if (errors == 0 && pending_grants.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
